/* src/mbrc_pkg.sv */
package mbrc_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_REPLY  = 3'd1;
  localparam logic [2:0] ST_INCOMPL   = 3'd2;
  localparam logic [2:0] ST_CRC_BAD   = 3'd3;
  localparam logic [2:0] ST_WRONG_SLV = 3'd4;
  localparam logic [2:0] ST_EXCEPTION = 3'd5;
  localparam logic [2:0] ST_WRONG_FN  = 3'd6;

  localparam logic [0:0] KIND_PAYLOAD = 1'b0;
  localparam logic [0:0] KIND_STATUS  = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FN_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FN_READ_INPUT   = 8'h04;
  localparam logic [8:0]  LEN_EXCEPTION   = 9'd5;
  localparam logic [8:0]  LEN_WRITE       = 9'd8;
  localparam logic [8:0]  LEN_READ_EXTRA  = 9'd5;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [7:0]  SLAVE_RESET     = 8'd1;

  typedef struct packed {
    logic [0:0] kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [8:0] bytes_seen;
    logic [0:0] last;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/mbrc_frame.sv */
module mbrc_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          cmd,
  input  logic [7:0]          expected_function,
  input  logic [7:0]          rx_byte,
  input  logic [7:0]          slave_address,
  input  logic [15:0]         timeout_ticks,
  output logic                res_vld,
  output mbrc_pkg::res_t      res
);
  import mbrc_pkg::*;

  logic        armed_r, armed_nxt;
  logic [7:0]  want_r, want_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [8:0]  flen_r, flen_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail_r, tail_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [7:0]  resp_r, resp_nxt;
  logic [7:0]  exc_r, exc_nxt;
  logic [15:0] cnt_r, cnt_nxt;

  logic        is_read;
  logic [8:0]  flen_new;
  logic [9:0]  idx_plus2;
  logic [8:0]  seen;
  logic [15:0] cnt_dec;
  logic [15:0] crc_upd;

  assign is_read   = (want_r == FN_READ_HOLDING) || (want_r == FN_READ_INPUT);
  assign idx_plus2 = {1'b0, idx_r} + 10'd2;
  assign seen      = idx_r + 9'd1;
  assign cnt_dec   = (cnt_r != 16'd0) ? cnt_r - 16'd1 : 16'd0;
  assign crc_upd   = crc_byte(crc_r, rx_byte);

  always_comb begin
    flen_new = flen_r;
    if (idx_r == 9'd1) begin
      if (rx_byte[7]) begin
        flen_new = LEN_EXCEPTION;
      end else if (!is_read) begin
        flen_new = LEN_WRITE;
      end
    end else if (idx_r == 9'd2 && !resp_r[7] && is_read) begin
      flen_new = {1'b0, rx_byte} + LEN_READ_EXTRA;
    end
  end

  always_comb begin
    armed_nxt = armed_r;
    want_nxt  = want_r;
    idx_nxt   = idx_r;
    flen_nxt  = flen_r;
    crc_nxt   = crc_r;
    tail_nxt  = tail_r;
    first_nxt = first_r;
    resp_nxt  = resp_r;
    exc_nxt   = exc_r;
    cnt_nxt   = cnt_r;
    res_vld   = 1'b0;
    res       = '0;
    if (accept) begin
      unique case (cmd)
        CMD_START: begin
          armed_nxt = 1'b1;
          want_nxt  = expected_function;
          idx_nxt   = 9'd0;
          flen_nxt  = 9'd0;
          crc_nxt   = CRC_INIT;
          tail_nxt  = 8'd0;
          first_nxt = 8'd0;
          resp_nxt  = 8'd0;
          exc_nxt   = 8'd0;
          cnt_nxt   = timeout_ticks;
        end
        CMD_TICK: begin
          if (armed_r) begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 16'd0) begin
              armed_nxt      = 1'b0;
              res_vld        = 1'b1;
              res.kind       = KIND_STATUS;
              res.status     = (idx_r == 9'd0) ? ST_NO_REPLY : ST_INCOMPL;
              res.bytes_seen = idx_r;
              res.last       = 1'b1;
            end
          end
        end
        CMD_BYTE: begin
          if (armed_r) begin
            idx_nxt  = seen;
            flen_nxt = flen_new;
            if (idx_r == 9'd0) begin
              first_nxt = rx_byte;
            end else if (idx_r == 9'd1) begin
              resp_nxt = rx_byte;
            end else if (idx_r == 9'd2 && resp_r[7]) begin
              exc_nxt = rx_byte;
            end
            if (idx_r < 9'd2 || idx_plus2 < {1'b0, flen_new}) begin
              crc_nxt = crc_upd;
              if (idx_r >= 9'd2) begin
                res_vld        = 1'b1;
                res.kind       = KIND_PAYLOAD;
                res.data_byte  = rx_byte;
                res.bytes_seen = seen;
              end
            end else if (idx_plus2 == {1'b0, flen_new}) begin
              tail_nxt = rx_byte;
            end else begin
              armed_nxt      = 1'b0;
              res_vld        = 1'b1;
              res.kind       = KIND_STATUS;
              res.bytes_seen = seen;
              res.last       = 1'b1;
              priority if ({rx_byte, tail_r} != crc_r) begin
                res.status = ST_CRC_BAD;
              end else if (first_r != slave_address) begin
                res.status = ST_WRONG_SLV;
              end else if (resp_r[7]) begin
                res.status         = ST_EXCEPTION;
                res.exception_code = exc_r;
              end else if (resp_r != want_r) begin
                res.status = ST_WRONG_FN;
              end else begin
                res.status = ST_OK;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= 1'b0;
    end else begin
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    want_r  <= want_nxt;
    idx_r   <= idx_nxt;
    flen_r  <= flen_nxt;
    crc_r   <= crc_nxt;
    tail_r  <= tail_nxt;
    first_r <= first_nxt;
    resp_r  <= resp_nxt;
    exc_r   <= exc_nxt;
    cnt_r   <= cnt_nxt;
  end

endmodule

/* src/mbrc_out_reg.sv */
module mbrc_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  mbrc_pkg::res_t res,
  output logic           slot_free,
  output logic           out_valid,
  input  logic           out_ready,
  output mbrc_pkg::res_t out_res
);
  import mbrc_pkg::*;

  logic vld_r, vld_nxt;
  res_t res_r;

  assign slot_free = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

/* src/modbus_rtu_response_checker.sv */
// Modbus RTU response receiver. A start word arms it with the expected function code and
// loads the timeout from timeout_ticks; byte words then carry the response, and tick words
// count the timeout down. Payload bytes come out as they arrive, and the frame's last byte
// (or the timeout) gives one final status word with last set: CRC mismatch is checked
// first, then slave address, then device exception, then function. The CRC update and all
// checks sit between the accepted word and the output register, so a word is accepted in
// every cycle as long as the output register is empty or being drained.
module modbus_rtu_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_expected_function,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [0:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [2:0]  out_status,
  output logic [7:0]  out_exception_code,
  output logic [8:0]  out_bytes_seen,
  output logic [0:0]  out_last
);
  import mbrc_pkg::*;

  logic [7:0]  slave_r;
  logic [15:0] timeout_r;
  logic        accept;
  logic        res_vld;
  res_t        res;
  res_t        out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_r   <= SLAVE_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_SLAVE_ADDRESS) begin
        slave_r <= cfg_data[7:0];
      end else if (cfg_index == REG_TIMEOUT_TICKS) begin
        timeout_r <= cfg_data;
      end
    end
  end

  assign accept = in_valid && in_ready;

  mbrc_frame u_frame (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .cmd               (in_cmd),
    .expected_function (in_expected_function),
    .rx_byte           (in_rx_byte),
    .slave_address     (slave_r),
    .timeout_ticks     (timeout_r),
    .res_vld           (res_vld),
    .res               (res)
  );

  mbrc_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_vld),
    .res       (res),
    .slot_free (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_kind           = out_res.kind;
  assign out_data_byte      = out_res.data_byte;
  assign out_status         = out_res.status;
  assign out_exception_code = out_res.exception_code;
  assign out_bytes_seen     = out_res.bytes_seen;
  assign out_last           = out_res.last;

endmodule
